/* hw/rtl/srrw_pkg.sv */
// Shared types, constants and helpers for the selective-repeat receiver window.
// No dependencies; every other file in hw/rtl imports this package.
package srrw_pkg;

   localparam int SEQ_W       = 8;
   localparam int WIN_W       = 6;
   localparam int MAX_WINDOW  = 32;
   localparam int SLOT_W      = $clog2(MAX_WINDOW);
   localparam int RESULT_CAP  = 32;
   localparam int CNT_W       = $clog2(RESULT_CAP + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);
   localparam logic [SEQ_W-1:0] SEQ_LAST  = {SEQ_W{1'b1}};

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_NAK = 1'b1;

   // One classified frame handed from the front end to the back end
   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [SLOT_W-1:0] slot;
   } frame_type;

   // Clamp the programmed width to 1 .. MAX_WINDOW
   function automatic logic [WIN_W-1:0] eff_width(input logic [WIN_W-1:0] sz);
      logic [WIN_W-1:0] w;
      w = sz;
      if (sz == '0) begin
         w = WIN_W'(1);
      end else if (sz > WIN_W'(MAX_WINDOW)) begin
         w = WIN_W'(MAX_WINDOW);
      end
      return w;
   endfunction

   // One restoring remainder step: shift in one dividend bit, subtract if it fits
   function automatic logic [SLOT_W-1:0] mod_step(input logic [SLOT_W-1:0] rem,
                                                  input logic              dbit,
                                                  input logic [WIN_W-1:0]  w);
      logic [SLOT_W:0] r;
      r = {rem, dbit};
      if (r >= (SLOT_W+1)'(w)) begin
         r = r - (SLOT_W+1)'(w);
      end
      return r[SLOT_W-1:0];
   endfunction

endpackage

/* hw/rtl/srrw_mod_unit.sv */
// Iterative remainder unit: 8-bit value modulo the window width, two bits per cycle.
// Depends on srrw_pkg.
module srrw_mod_unit
   import srrw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start_i,
   input  logic [SEQ_W-1:0]  dividend_i,
   input  logic [WIN_W-1:0]  divisor_i,
   output logic              done_o,
   output logic [SLOT_W-1:0] rem_o
);

   localparam int STEPS = SEQ_W / 2;
   localparam int STEP_W = $clog2(STEPS);

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SLOT_W-1:0]   rem_ff, rem_in;
   logic [SEQ_W-1:0]    dvd_ff, dvd_in;
   logic [SLOT_W-1:0]   rem_mid, rem_new;

   assign rem_mid = mod_step(rem_ff, dvd_ff[SEQ_W-1], divisor_i);
   assign rem_new = mod_step(rem_mid, dvd_ff[SEQ_W-2], divisor_i);
   assign done_o  = busy_ff && (step_ff == STEP_W'(STEPS - 1));
   assign rem_o   = rem_new;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (busy_ff) begin
         rem_in  = rem_new;
         dvd_in  = {dvd_ff[SEQ_W-3:0], 2'b00};
         step_in = step_ff + STEP_W'(1);
         if (done_o) begin
            busy_in = 1'b0;
         end
      end else if (start_i) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

endmodule

/* hw/rtl/srrw_front.sv */
// Front end: accepts a frame request and computes its bitmap slot (seq mod width).
// Depends on srrw_pkg and srrw_mod_unit.
module srrw_front
   import srrw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SEQ_W-1:0] req_seq_num,
   input  logic [WIN_W-1:0] win_w_i,
   input  logic             q_full_i,
   output logic             push_o,
   output frame_type        push_data_o
);

   logic             busy_ff, busy_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic             accept;
   logic             mod_done;
   logic [SLOT_W-1:0] mod_rem;

   assign req_stall = busy_ff || q_full_i;
   assign accept    = req_valid && !req_stall;

   srrw_mod_unit u_mod (
      .clock      (clock),
      .reset      (reset),
      .start_i    (accept),
      .dividend_i (req_seq_num),
      .divisor_i  (win_w_i),
      .done_o     (mod_done),
      .rem_o      (mod_rem)
   );

   // queue space was checked at accept and only this side fills it
   assign push_o           = mod_done;
   assign push_data_o.seq  = seq_ff;
   assign push_data_o.slot = mod_rem;

   always_comb begin
      busy_in = busy_ff;
      seq_in  = seq_ff;
      if (accept) begin
         busy_in = 1'b1;
         seq_in  = req_seq_num;
      end else if (mod_done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      seq_ff <= seq_in;
   end

endmodule

/* hw/rtl/srrw_queue.sv */
// Small FIFO of classified frames between the front end and the back end.
// Depends on srrw_pkg.
module srrw_queue
   import srrw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_i,
   input  frame_type push_data_i,
   input  logic      pop_i,
   output logic      valid_o,
   output logic      full_o,
   output frame_type head_o
);

   frame_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
      logic [QUEUE_AW-1:0] n;
      n = p + QUEUE_AW'(1);
      if (p == QUEUE_AW'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

   assign valid_o = (count_ff != '0);
   assign full_o  = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_o  = mem_ff[rd_ptr_ff];
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && valid_o;

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data_i;
      end
   end

endmodule

/* hw/rtl/srrw_back.sv */
// Back end: NAK decision, arrival bitmap, release walk and the reply output register.
// Depends on srrw_pkg and srrw_mod_unit.
module srrw_back
   import srrw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [WIN_W-1:0] win_w_i,
   input  logic             csr_we_i,
   input  logic             q_valid_i,
   input  frame_type        q_head_i,
   output logic             q_pop_o,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_reply_kind,
   output logic [SEQ_W-1:0] rsp_reply_num,
   output logic             rsp_last_reply
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_FIX  = 2'd1;
   localparam logic [1:0] B_NAK  = 2'd2;
   localparam logic [1:0] B_WALK = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic [SLOT_W-1:0]     exp_slot_ff, exp_slot_in;
   logic                  nak_allowed_ff, nak_allowed_in;
   logic [MAX_WINDOW-1:0] arrived_ff, arrived_in;
   logic                  stale_ff, stale_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]      rsp_num_ff, rsp_num_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free;
   logic [SEQ_W-1:0]      seq_gap;
   logic                  in_win, mark, nak, walk_go, more;
   logic [SLOT_W:0]       slot_inc;
   logic [SLOT_W-1:0]     next_slot;
   logic [MAX_WINDOW-1:0] cleared;
   logic                  fix_start, fix_done;
   logic [SLOT_W-1:0]     fix_rem;

   assign fix_start = (state_ff == B_IDLE) && q_valid_i && stale_ff;

   // recompute the lower-edge slot after the width has been rewritten
   srrw_mod_unit u_fix (
      .clock      (clock),
      .reset      (reset),
      .start_i    (fix_start),
      .dividend_i (expected_ff),
      .divisor_i  (win_w_i),
      .done_o     (fix_done),
      .rem_o      (fix_rem)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign seq_gap  = seq_ff - expected_ff;
   assign in_win   = seq_gap < SEQ_W'(win_w_i);
   assign mark     = in_win && !arrived_ff[slot_ff];
   assign nak      = (seq_ff != expected_ff) && nak_allowed_ff;
   assign walk_go  = mark && (arrived_ff[exp_slot_ff] || (slot_ff == exp_slot_ff));

   assign slot_inc = {1'b0, exp_slot_ff} + (SLOT_W+1)'(1);
   always_comb begin
      if (expected_ff == SEQ_LAST) begin
         next_slot = '0;
      end else if (slot_inc == (SLOT_W+1)'(win_w_i)) begin
         next_slot = '0;
      end else begin
         next_slot = slot_inc[SLOT_W-1:0];
      end
   end

   assign cleared = arrived_ff & ~(MAX_WINDOW'(1) << exp_slot_ff);
   assign more    = cleared[next_slot] && (count_ff != CNT_W'(RESULT_CAP - 1));

   always_comb begin
      state_in       = state_ff;
      expected_in    = expected_ff;
      exp_slot_in    = exp_slot_ff;
      nak_allowed_in = nak_allowed_ff;
      arrived_in     = arrived_ff;
      stale_in       = stale_ff;
      seq_in         = seq_ff;
      slot_in        = slot_ff;
      count_in       = count_ff;
      q_pop_o        = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_num_in     = rsp_num_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid_i) begin
               q_pop_o  = 1'b1;
               seq_in   = q_head_i.seq;
               slot_in  = q_head_i.slot;
               state_in = stale_ff ? B_FIX : B_NAK;
            end
         end
         B_FIX: begin
            if (fix_done) begin
               exp_slot_in = fix_rem;
               stale_in    = 1'b0;
               state_in    = B_NAK;
            end
         end
         B_NAK: begin
            // hold while a NAK has no room in the output register
            if (!nak || out_free) begin
               if (nak) begin
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_NAK;
                  rsp_num_in     = expected_ff;
                  rsp_last_in    = !walk_go;
                  nak_allowed_in = 1'b0;
               end
               if (mark) begin
                  arrived_in[slot_ff] = 1'b1;
               end
               count_in = nak ? CNT_W'(1) : '0;
               state_in = walk_go ? B_WALK : B_IDLE;
            end
         end
         B_WALK: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_ACK;
               rsp_num_in     = expected_ff;
               rsp_last_in    = !more;
               arrived_in     = cleared;
               nak_allowed_in = 1'b1;
               expected_in    = expected_ff + SEQ_W'(1);
               exp_slot_in    = next_slot;
               count_in       = count_ff + CNT_W'(1);
               if (!more) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      if (csr_we_i) begin
         stale_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= B_IDLE;
         expected_ff    <= '0;
         exp_slot_ff    <= '0;
         nak_allowed_ff <= 1'b1;
         arrived_ff     <= '0;
         stale_ff       <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         expected_ff    <= expected_in;
         exp_slot_ff    <= exp_slot_in;
         nak_allowed_ff <= nak_allowed_in;
         arrived_ff     <= arrived_in;
         stale_ff       <= stale_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      seq_ff      <= seq_in;
      slot_ff     <= slot_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_reply_num  = rsp_num_ff;
   assign rsp_last_reply = rsp_last_ff;

endmodule

/* hw/rtl/selective_repeat_receiver_window_core.sv */
// Top level of the selective-repeat receiver window: width register, front end,
// frame queue and back end. Depends on srrw_pkg, srrw_front, srrw_queue, srrw_back.
//
//   Port group   Direction   Handshake            Carries
//   req_*        in          req_valid/req_stall  received frame sequence number
//   rsp_*        out         rsp_valid/rsp_stall  ACK/NAK replies, last marks end of run
//   csr_*        in          csr_we               receive window width
//
// The front end takes one request at a time: the slot (seq mod width) comes from
// a remainder unit that retires two bits a cycle. For each request the back end pops
// the queue, decides on a NAK, then walks the ACK releases; on the first request after
// a width write it first recomputes the lower-edge slot. A two-entry queue lets
// the front keep accepting while the back end waits on rsp_stall. Reset clears the
// window state and sets the width to 8.
module selective_repeat_receiver_window_core
   import srrw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SEQ_W-1:0] req_seq_num,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic             rsp_reply_kind,
   output logic [SEQ_W-1:0] rsp_reply_num,
   output logic             rsp_last_reply,
   input  logic             csr_we,
   input  logic [WIN_W-1:0] csr_wdata
);

   logic [WIN_W-1:0] window_size_ff, window_size_in;
   logic [WIN_W-1:0] win_w;
   logic             q_push, q_pop, q_valid, q_full;
   frame_type        q_push_data, q_head;

   assign window_size_in = csr_we ? csr_wdata : window_size_ff;
   assign win_w          = eff_width(window_size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WIN_RESET;
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   srrw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_seq_num (req_seq_num),
      .win_w_i     (win_w),
      .q_full_i    (q_full),
      .push_o      (q_push),
      .push_data_o (q_push_data)
   );

   srrw_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (q_push),
      .push_data_i (q_push_data),
      .pop_i       (q_pop),
      .valid_o     (q_valid),
      .full_o      (q_full),
      .head_o      (q_head)
   );

   srrw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .win_w_i        (win_w),
      .csr_we_i       (csr_we),
      .q_valid_i      (q_valid),
      .q_head_i       (q_head),
      .q_pop_o        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_reply_num  (rsp_reply_num),
      .rsp_last_reply (rsp_last_reply)
   );

endmodule

/* hw/rtl/srrw_checker.sv */
// Port-level checks for the selective-repeat receiver window, bound to the top level.
// Depends on srrw_pkg and selective_repeat_receiver_window_core.
module srrw_checker
   import srrw_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_reply_kind,
   input logic [SEQ_W-1:0] rsp_reply_num,
   input logic             rsp_last_reply
);

   logic rsp_take;
   assign rsp_take = rsp_valid && !rsp_stall;

   // no reply comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("reply valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_kind)
         && $stable(rsp_reply_num) && $stable(rsp_last_reply))
      else $error("stalled reply changed");

   // the front end is busy computing the slot after taking a request
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

   // a NAK that is not last is followed by the release walk, never another NAK
   a_nak_then_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_reply_kind == KIND_NAK && !rsp_last_reply
         |=> !(rsp_valid && rsp_reply_kind == KIND_NAK))
      else $error("NAK followed by NAK in one run");

   // releases advance the lower edge by one
   a_ack_order: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_reply_kind == KIND_ACK && !rsp_last_reply
         |=> !rsp_valid || (rsp_reply_kind == KIND_ACK
            && rsp_reply_num == $past(rsp_reply_num) + SEQ_W'(1)))
      else $error("ACK numbers not consecutive");

endmodule

bind selective_repeat_receiver_window_core srrw_checker u_srrw_checker (.*);

/* bench/tb_selective_repeat_receiver_window_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for selective_repeat_receiver_window_core: frame
// requests in, ACK/NAK replies checked against a window predictor.
// Depends on srrw_pkg and the RTL of the core.

typedef struct packed {
   logic       kind;
   logic [7:0] num;
   logic       last;
} srrw_reply_type;

class window_scoreboard;
   logic [5:0]     width_reg;
   logic [7:0]     lower_edge;
   bit             nak_free;
   bit             arrived [srrw_pkg::MAX_WINDOW];
   srrw_reply_type awaited [$];
   int             mismatches;

   function new();
      width_reg  = 6'd8;
      lower_edge = 8'd0;
      nak_free   = 1'b1;
      foreach (arrived[i]) arrived[i] = 1'b0;
      mismatches = 0;
   endfunction

   // Programmed width clamped to 1 .. MAX_WINDOW
   function int unsigned span();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > srrw_pkg::MAX_WINDOW) w = srrw_pkg::MAX_WINDOW;
      return w;
   endfunction

   function void push_reply(logic kind, logic [7:0] num);
      srrw_reply_type r;
      r.kind = kind;
      r.num  = num;
      r.last = 1'b0;
      awaited.push_back(r);
   endfunction

   function void note_request(logic [7:0] seq);
      int unsigned w;
      int unsigned seq_gap;
      int unsigned slot;
      int          n;
      w = span();
      n = 0;
      if (seq != lower_edge && nak_free) begin
         push_reply(srrw_pkg::KIND_NAK, lower_edge);
         n++;
         nak_free = 1'b0;
      end
      seq_gap = (seq + 256 - lower_edge) % 256;
      slot = seq % w;
      if (seq_gap < w && !arrived[slot]) begin
         arrived[slot] = 1'b1;
         // release in-order frames from the lower edge, capped per request
         while (n < srrw_pkg::RESULT_CAP && arrived[lower_edge % w]) begin
            arrived[lower_edge % w] = 1'b0;
            nak_free = 1'b1;
            push_reply(srrw_pkg::KIND_ACK, lower_edge);
            n++;
            lower_edge = lower_edge + 8'd1;
         end
      end
      if (n > 0) awaited[awaited.size() - 1].last = 1'b1;
   endfunction

   function void flag(string what, srrw_reply_type want, logic kind, logic [7:0] num,
                      logic last);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected kind %0d num %0d last %0d, got kind %0d num %0d last %0d",
                  $realtime, what, want.kind, want.num, want.last, kind, num, last);
   endfunction

   function void check_reply(logic kind, logic [7:0] num, logic last);
      srrw_reply_type want;
      if (awaited.size() == 0) begin
         want = '0;
         flag("reply with nothing pending", want, kind, num, last);
         return;
      end
      want = awaited.pop_front();
      if (want.kind !== kind || want.num !== num || want.last !== last)
         flag("reply mismatch", want, kind, num, last);
   endfunction
endclass

module tb_selective_repeat_receiver_window_core;
   import srrw_pkg::*;

   localparam int PHASE_ITEMS = 50;
   localparam logic [7:0] OPENING [17] = '{
      8'd0, 8'd2, 8'd3, 8'd1, 8'd1, 8'd255, 8'd9, 8'd4, 8'd12,
      8'd11, 8'd10, 8'd8, 8'd7, 8'd6, 8'd5, 8'd128, 8'd13};
   localparam logic [WIN_W-1:0] WIDTH_PLAN [7] = '{
      6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd16, 6'd33};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [SEQ_W-1:0] req_seq_num = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_reply_kind;
   logic [SEQ_W-1:0] rsp_reply_num;
   logic             rsp_last_reply;
   logic             csr_we = 1'b0;
   logic [WIN_W-1:0] csr_wdata = '0;

   bit               hold_off_req = 1'b0;
   window_scoreboard sb;

   selective_repeat_receiver_window_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_seq_num    (req_seq_num),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_kind (rsp_reply_kind),
      .rsp_reply_num  (rsp_reply_num),
      .rsp_last_reply (rsp_last_reply),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Offer one request and hold it until the edge that takes it
   task automatic send_request(input logic [SEQ_W-1:0] seq);
      req_valid   <= 1'b1;
      req_seq_num <= seq;
      do @(posedge clock); while (req_stall);
      sb.note_request(seq);
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Drop valid, wait for every reply, then let silent requests drain
   task automatic settle();
      rest(1);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_width(input logic [WIN_W-1:0] w);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      sb.width_reg = w;
      csr_we    <= 1'b0;
   endtask

   // Mostly frames inside the window in random order, some stale and some noise
   function automatic logic [SEQ_W-1:0] pick_seq();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return SEQ_W'($urandom_range(0, 255));
      if (roll < 18) return sb.lower_edge - SEQ_W'($urandom_range(1, 4));
      if (roll < 24) return sb.lower_edge;
      return sb.lower_edge + SEQ_W'($urandom_range(0, sb.span() - 1));
   endfunction

   task automatic run_phase(input int count, input bit squeeze);
      int sent;
      int burst;
      sent = 0;
      if (squeeze) hold_off_req = 1'b1;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < count) begin
            send_request(pick_seq());
            sent++;
            burst--;
         end
         // keep the input full while the receiver holds off
         if (!squeeze && $urandom_range(0, 2) != 0) rest($urandom_range(1, 8));
      end
   endtask

   initial begin : main_seq
      logic [WIN_W-1:0] w;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (OPENING[i]) send_request(OPENING[i]);
      settle();

      for (int p = 0; p < 8; p++) begin
         w = (p < 7) ? WIDTH_PLAN[p] : WIN_W'($urandom_range(0, 63));
         write_width(w);
         run_phase(PHASE_ITEMS, p == 1);
         settle();
      end

      sb.mismatches += sb.awaited.size();
      if (sb.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Receiver stall pattern, with one long hold-off on request
   initial begin : rsp_stall_gen
      int mode;
      int stretch;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            repeat (400) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(10, 80);
         for (int k = 0; k < stretch; k++) begin
            @(posedge clock);
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= ($urandom_range(0, 3) != 0);
               end
               default: begin
                  rsp_stall <= (k % 3 != 0);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_reply(rsp_reply_kind, rsp_reply_num, rsp_last_reply);
   end

   initial begin : watchdog
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/srrw_pkg.sv
hw/rtl/srrw_mod_unit.sv
hw/rtl/srrw_front.sv
hw/rtl/srrw_queue.sv
hw/rtl/srrw_back.sv
hw/rtl/selective_repeat_receiver_window_core.sv
hw/rtl/srrw_checker.sv
bench/tb_selective_repeat_receiver_window_core.sv
